### design/fpt_pkg.sv
// Shared types and constants of the fan PWM and tachometer controller.
package fpt_pkg;

	// Input stream layout
	localparam int unsigned IN_DATA_W = 16;
	localparam int unsigned IN_USER_W = 3;
	// Output stream layout
	localparam int unsigned OUT_DATA_W = 32;
	localparam int unsigned OUT_USER_W = 2;
	// Configuration port
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// Shared divider
	localparam int unsigned DIV_W = 32;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

	// Item kinds carried in the low bits of the input tuser
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_EDGE  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	// PWM output modes
	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_PWM = 2'd1;
	localparam logic [1:0] MODE_ON  = 2'd2;

	// Bus register addresses
	localparam logic [7:0] ADDR_DUTY = 8'd0;
	localparam logic [7:0] ADDR_RPM  = 8'd1;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_PWM_TOP   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_NUMERATOR = 2'd2;

	// Reset values of the configuration registers
	localparam logic [7:0]  PWM_TOP_RESET   = 8'd159;
	localparam logic [31:0] TIMEOUT_RESET   = 32'd1000000;
	localparam logic [31:0] NUMERATOR_RESET = 32'd15000000;

	// Duty and speed constants
	localparam logic [7:0]  DUTY_ZERO  = 8'd0;
	localparam logic [7:0]  DUTY_FULL  = 8'd255;
	localparam logic [15:0] ROUND_HALF = 16'd127;
	localparam logic [15:0] RPM_MAX    = 16'hFFFF;

	// Sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

endpackage

### design/fan_pwm_tach_controller.sv
// Top level of the fan PWM and tachometer controller: sequencer, state and stream ports.
// Usage. Every transaction on the input stream is one item: a microsecond tick, a tach
// edge, a bus write or a bus read, selected by s_axis_tuser. Each item gives exactly one
// transaction on the output stream with the PWM mode and compare value after the item,
// and for a bus read of the rpm register the speed and its saturation flag.
// Configuration registers (PWM top, timeout, rpm numerator) are written through the cfg
// channel, which is always ready; the user must make writes while the block is idle,
// as the block does not enforce it. An index with no register behind it is ignored.
// Sequencing. An rpm read within the timeout with a measured interval runs the shared
// 32-bit divider, one quotient bit per cycle, between the execute and done states. Every
// other item, duty writes included, goes from the execute state straight to the done
// state. One item is worked on at a time, so s_axis_tready is high only while the
// sequencer is idle.
// Reset. arst_n clears the time counter, edge time, interval, pointer, duty compare and
// mode, loads the configuration reset values and empties the output register.
// Stalls. A result waits in the output register until taken; the next item may be
// accepted meanwhile, and its result is held back until the slot is free.
module fan_pwm_tach_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// tdata: reg_addr [7:0], write_data [15:8]
	input  logic [fpt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// tuser: cmd [1:0], has_data [2]
	input  logic [fpt_pkg::IN_USER_W-1:0]    s_axis_tuser,
	// Output stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// tdata: pwm_mode [1:0], pwm_compare [9:2], read_data [25:10], zeros [31:26]
	output logic [fpt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// tuser: read_valid [0], rpm_saturated [1]
	output logic [fpt_pkg::OUT_USER_W-1:0]   m_axis_tuser,
	// Configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [fpt_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fpt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	fpt_pkg::state_t state_q;

	// Configuration registers
	logic [7:0]  pwm_top_q;
	logic [31:0] timeout_q;
	logic [31:0] numerator_q;

	// Block state
	logic [31:0] now_q;
	logic [31:0] last_edge_q;
	logic [31:0] interval_q;
	logic [7:0]  reg_ptr_q;
	logic [7:0]  duty_cmp_q;
	logic [1:0]  mode_q;

	// Captured item
	fpt_pkg::cmd_t cmd_q;
	logic [7:0]    addr_q;
	logic          has_q;
	logic [7:0]    wdata_q;

	// Read result of the item in flight
	logic        rvalid_q;
	logic [15:0] rdata_q;
	logic        rsat_q;

	// Output register
	logic                            out_valid_q;
	logic [fpt_pkg::OUT_DATA_W-1:0]  out_data_q;
	logic [fpt_pkg::OUT_USER_W-1:0]  out_user_q;

	// Shared divider hookup
	logic        div_start;
	logic        div_done;
	logic [31:0] div_quotient;

	logic        in_fire;
	logic        out_free;
	logic [31:0] gap;
	logic [31:0] elapsed;
	logic [15:0] duty_product;
	logic [15:0] duty_scaled;
	logic        rpm_read;
	logic        rpm_live;
	logic        rpm_ceiling;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	assign s_axis_tready = (state_q == fpt_pkg::ST_IDLE);
	assign cfg_ready     = 1'b1;

	assign gap     = now_q - last_edge_q;
	assign elapsed = now_q - last_edge_q;
	// The product plus rounding stays below 2^16 for any duty and top.
	assign duty_product = 16'(wdata_q * pwm_top_q) + fpt_pkg::ROUND_HALF;
	// Division by 255 is exact as (x + (x >> 8) + 1) >> 8 for any x below 65280. The
	// rounded product is at most 64897, so the sum cannot overflow 16 bits.
	assign duty_scaled = duty_product + {8'd0, duty_product[15:8]} + 16'd1;

	// A read of the rpm register reports a speed only when an edge came within the
	// timeout; with no interval measured yet it reports the ceiling, otherwise it divides.
	assign rpm_read    = (cmd_q == fpt_pkg::CMD_READ) && (reg_ptr_q == fpt_pkg::ADDR_RPM);
	assign rpm_live    = rpm_read && (elapsed < timeout_q);
	assign rpm_ceiling = rpm_live && (interval_q == 32'd0);
	assign div_start   = (state_q == fpt_pkg::ST_EXEC) && rpm_live && (interval_q != 32'd0);

	fpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (numerator_q),
		.divisor  (interval_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_top_q   <= fpt_pkg::PWM_TOP_RESET;
			timeout_q   <= fpt_pkg::TIMEOUT_RESET;
			numerator_q <= fpt_pkg::NUMERATOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fpt_pkg::CFG_PWM_TOP:   pwm_top_q   <= cfg_data[7:0];
				fpt_pkg::CFG_TIMEOUT:   timeout_q   <= cfg_data;
				fpt_pkg::CFG_NUMERATOR: numerator_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Item capture; payload only
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q   <= fpt_pkg::cmd_t'(s_axis_tuser[1:0]);
			has_q   <= s_axis_tuser[2];
			addr_q  <= s_axis_tdata[7:0];
			wdata_q <= s_axis_tdata[15:8];
		end
	end

	// Sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpt_pkg::ST_IDLE;
			now_q       <= '0;
			last_edge_q <= '0;
			interval_q  <= '0;
			reg_ptr_q   <= '0;
			duty_cmp_q  <= '0;
			mode_q      <= fpt_pkg::MODE_OFF;
			rvalid_q    <= 1'b0;
			rdata_q     <= '0;
			rsat_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The output slot fills when a result is done and drains when it is taken.
			if ((state_q == fpt_pkg::ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				fpt_pkg::ST_IDLE: begin
					if (in_fire) begin
						state_q <= fpt_pkg::ST_EXEC;
					end
				end
				fpt_pkg::ST_EXEC: begin
					rvalid_q <= rpm_read;
					rdata_q  <= rpm_ceiling ? fpt_pkg::RPM_MAX : 16'd0;
					rsat_q   <= rpm_ceiling;
					state_q  <= div_start ? fpt_pkg::ST_DIV : fpt_pkg::ST_DONE;
					case (cmd_q)
						fpt_pkg::CMD_TICK: begin
							now_q <= now_q + 32'd1;
						end
						fpt_pkg::CMD_EDGE: begin
							// Smoothed interval: three quarters old plus a quarter of the gap.
							interval_q  <= interval_q - (interval_q >> 2) + (gap >> 2);
							last_edge_q <= now_q;
						end
						fpt_pkg::CMD_WRITE: begin
							reg_ptr_q <= addr_q;
							if ((addr_q == fpt_pkg::ADDR_DUTY) && has_q) begin
								if (wdata_q == fpt_pkg::DUTY_ZERO) begin
									mode_q <= fpt_pkg::MODE_OFF;
								end else if (wdata_q == fpt_pkg::DUTY_FULL) begin
									mode_q <= fpt_pkg::MODE_ON;
								end else begin
									mode_q     <= fpt_pkg::MODE_PWM;
									duty_cmp_q <= duty_scaled[15:8];
								end
							end
						end
						// A read changes no state; its result is set above.
						default: ;
					endcase
				end
				fpt_pkg::ST_DIV: begin
					if (div_done) begin
						state_q <= fpt_pkg::ST_DONE;
						if (div_quotient[31:16] != 16'd0) begin
							rdata_q <= fpt_pkg::RPM_MAX;
							rsat_q  <= 1'b1;
						end else begin
							rdata_q <= div_quotient[15:0];
						end
					end
				end
				fpt_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= fpt_pkg::ST_IDLE;
					end
				end
				default: state_q <= fpt_pkg::ST_IDLE;
			endcase
		end
	end

	// Output payload; loaded together with the valid flag
	always_ff @(posedge clk) begin
		if ((state_q == fpt_pkg::ST_DONE) && out_free) begin
			out_data_q <= {6'd0, rdata_q, duty_cmp_q, mode_q};
			out_user_q <= {rsat_q, rvalid_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

### design/fpt_div.sv
// Shared iterative unsigned divider, one quotient bit per cycle.
module fpt_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fpt_pkg::DIV_W-1:0]  dividend,
	input  logic [fpt_pkg::DIV_W-1:0]  divisor,
	output logic                       done,
	output logic [fpt_pkg::DIV_W-1:0]  quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [fpt_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [fpt_pkg::DIV_W-1:0]     rem_q;
	logic [fpt_pkg::DIV_W-1:0]     quo_q;
	logic [fpt_pkg::DIV_W-1:0]     divisor_q;
	logic [fpt_pkg::DIV_W:0]       trial;
	logic                          fits;

	// The partial remainder stays below the divisor, so bit DIV_W of the
	// difference is a clean borrow flag.
	always_comb begin
		trial = {rem_q, quo_q[fpt_pkg::DIV_W-1]} - {1'b0, divisor_q};
		fits  = ~trial[fpt_pkg::DIV_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == fpt_pkg::DIV_CNT_W'(fpt_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= trial[fpt_pkg::DIV_W-1:0];
			end else begin
				rem_q <= {rem_q[fpt_pkg::DIV_W-2:0], quo_q[fpt_pkg::DIV_W-1]};
			end
			quo_q <= {quo_q[fpt_pkg::DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### design/fpt_checker.sv
// Port-level checks of the fan PWM and tachometer controller, bound to the top level.
module fpt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [fpt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input logic [fpt_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

	// A result held back by the receiver keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output transaction changed while stalled");

	// One item at a time: no acceptance right after an acceptance.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while an item is in progress");

	// Saturation is only reported on an rpm read, and then at the ceiling.
	a_sat_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
			m_axis_tuser[0] && (m_axis_tdata[25:10] == fpt_pkg::RPM_MAX))
		else $error("saturation flag without a saturated read");

	// No read data unless the item was an rpm read.
	a_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata[25:10] == 16'd0))
		else $error("read data on a non-read result");

	// Mode code three is never produced.
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
		else $error("invalid PWM mode");

endmodule

bind fan_pwm_tach_controller fpt_checker u_fpt_checker (.*);
